### hw/rtl/sed_pkg.sv
// Shared types, widths and constants for the simplex element diameter unit.
package sed_pkg;

    localparam int COORD_W      = 24;
    localparam int MAX_VERTICES = 4;
    localparam int NUM_VERT     = 4;
    localparam int AXES         = 3;
    localparam int NUM_PAIRS    = 6;
    localparam int OUT_W        = 25;
    localparam int MAG_W        = COORD_W + 1;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int SUM_W        = SQ_W + 2;
    localparam int ROOT_STEPS   = (SUM_W + 1) / 2;
    localparam int CMP_W        = (MAG_W > OUT_W) ? MAG_W : OUT_W;
    localparam int CFG_W        = 2;
    localparam int CFG_IDX_W    = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_COORD_DIMS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIMPLEX_DIMS = 2'd1;

    localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    typedef logic [NUM_VERT-1:0][AXES-1:0][COORD_W-1:0] t_coords;
    typedef logic [NUM_PAIRS-1:0][AXES-1:0][MAG_W-1:0]  t_mags;
    typedef logic [NUM_PAIRS-1:0][AXES-1:0][SQ_W-1:0]   t_squares;
    typedef logic [NUM_PAIRS-1:0][SUM_W-1:0]            t_sums;

    typedef struct packed {
        logic valid;
        logic sat;
    } t_ctl;

endpackage

### hw/rtl/sed_diff.sv
// First stage: per-pair coordinate differences, magnitudes, masking by configuration and saturation.
module sed_diff
    import sed_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_coords          i_coords,
    input  logic [CFG_W-1:0] i_coord_dims,
    input  logic [CFG_W-1:0] i_simplex_dims,
    output t_mags            o_mags,
    output t_ctl             o_ctl
);

    t_mags r_mags;
    t_mags n_mags;
    t_ctl  r_ctl;
    t_ctl  n_ctl;

    always_comb begin
        logic [2:0]              nv;
        logic signed [MAG_W-1:0] d;
        logic [MAG_W-1:0]        mag;
        logic                    use_pair;
        logic                    use_axis;
        nv = 3'(i_simplex_dims) + 3'd1;
        if (nv > 3'(MAX_VERTICES)) begin
            nv = 3'(MAX_VERTICES);
        end
        n_ctl.valid = i_valid;
        n_ctl.sat   = 1'b0;
        for (int p = 0; p < NUM_PAIRS; p++) begin
            use_pair = {1'b0, PAIR_B[p]} < nv;
            for (int k = 0; k < AXES; k++) begin
                use_axis = 2'(k) < i_coord_dims;
                d = $signed({i_coords[PAIR_A[p]][k][COORD_W-1], i_coords[PAIR_A[p]][k]})
                  - $signed({i_coords[PAIR_B[p]][k][COORD_W-1], i_coords[PAIR_B[p]][k]});
                mag = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
                if (!(use_pair && use_axis)) begin
                    mag = '0;
                end else if (CMP_W'(mag) > CMP_W'(OUT_MAX)) begin
                    n_ctl.sat = 1'b1;
                    mag = '0;
                end
                n_mags[p][k] = mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mags <= n_mags;
        end
    end

    assign o_mags = r_mags;
    assign o_ctl  = r_ctl;

endmodule

### hw/rtl/sed_sqsum.sv
// Two stages: squares of the axis magnitudes, then the per-pair squared distance.
module sed_sqsum
    import sed_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_mags i_mags,
    input  t_ctl  i_ctl,
    output t_sums o_sums,
    output t_ctl  o_ctl
);

    t_squares r_sq;
    t_squares n_sq;
    t_ctl     r_sq_ctl;
    t_sums    r_sums;
    t_sums    n_sums;
    t_ctl     r_sum_ctl;

    always_comb begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
            for (int k = 0; k < AXES; k++) begin
                n_sq[p][k] = SQ_W'(i_mags[p][k]) * SQ_W'(i_mags[p][k]);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PAIRS; p++) begin
            n_sums[p] = '0;
            for (int k = 0; k < AXES; k++) begin
                n_sums[p] = n_sums[p] + SUM_W'(r_sq[p][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl  <= '0;
            r_sum_ctl <= '0;
        end else if (i_en) begin
            r_sq_ctl  <= i_ctl;
            r_sum_ctl <= r_sq_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;
    assign o_ctl  = r_sum_ctl;

endmodule

### hw/rtl/sed_max.sv
// Two-level registered tree that picks the largest squared pair distance.
module sed_max
    import sed_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_sums            i_sums,
    input  t_ctl             i_ctl,
    output logic [SUM_W-1:0] o_best,
    output t_ctl             o_ctl
);

    localparam int HALF = NUM_PAIRS / 2;

    logic [HALF-1:0][SUM_W-1:0] r_part;
    logic [HALF-1:0][SUM_W-1:0] n_part;
    t_ctl                       r_part_ctl;
    logic [SUM_W-1:0]           r_best;
    logic [SUM_W-1:0]           n_best;
    t_ctl                       r_best_ctl;

    always_comb begin
        for (int h = 0; h < HALF; h++) begin
            n_part[h] = (i_sums[2*h] > i_sums[2*h+1]) ? i_sums[2*h] : i_sums[2*h+1];
        end
    end

    always_comb begin
        n_best = r_part[0];
        for (int h = 1; h < HALF; h++) begin
            if (r_part[h] > n_best) begin
                n_best = r_part[h];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_ctl <= '0;
            r_best_ctl <= '0;
        end else if (i_en) begin
            r_part_ctl <= i_ctl;
            r_best_ctl <= r_part_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part <= n_part;
            r_best <= n_best;
        end
    end

    assign o_best = r_best;
    assign o_ctl  = r_best_ctl;

endmodule

### hw/rtl/sed_isqrt.sv
// Pipelined integer square root, one result bit resolved per stage.
module sed_isqrt
    import sed_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [SUM_W-1:0] i_value,
    input  t_ctl             i_ctl,
    output logic [SUM_W-1:0] o_root,
    output t_ctl             o_ctl
);

    logic [SUM_W-1:0] r_x   [ROOT_STEPS];
    logic [SUM_W-1:0] r_res [ROOT_STEPS];
    t_ctl             r_ctl [ROOT_STEPS];

    for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - i));

        logic [SUM_W-1:0] x_in;
        logic [SUM_W-1:0] res_in;
        t_ctl             ctl_in;
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] n_x;
        logic [SUM_W-1:0] n_res;

        if (i == 0) begin : g_first
            assign x_in   = i_value;
            assign res_in = '0;
            assign ctl_in = i_ctl;
        end else begin : g_next
            assign x_in   = r_x[i-1];
            assign res_in = r_res[i-1];
            assign ctl_in = r_ctl[i-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (x_in >= trial) begin
                n_x   = x_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else if (i_en) begin
                r_ctl[i] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]   <= n_x;
                r_res[i] <= n_res;
            end
        end
    end

    assign o_root = r_res[ROOT_STEPS-1];
    assign o_ctl  = r_ctl[ROOT_STEPS-1];

endmodule

### hw/rtl/simplex_element_diameter_unit.sv
// Top level of the simplex element diameter unit: configuration, pipeline and output register.
//
// Each input transaction carries four vertices of three signed 24-bit fixed-point
// coordinates; the unit returns the floor square root of the largest squared
// distance between any two used vertices, in the same binary point.
// Input channel: i_valid with o_stall; output channel: o_valid with i_stall.
// A transaction moves at a clock edge where valid is high and stall is low.
// The configuration port writes coord_dims (index 0) or simplex_dims (index 1)
// whenever i_cfg_we is high; write it only while no transaction is in flight.
// The pipeline accepts one transaction every cycle while o_stall is low. Between
// acceptance and the result lie one difference stage, one multiply stage, one sum stage,
// two maximum stages, 26 square-root stages (one root bit each) and the output register.
// When the receiver stalls a held result, the whole pipeline freezes and o_stall
// rises, so nothing is dropped or repeated; empty slots do not move during a stall.
// Synchronous reset empties the pipeline and sets both registers to 3.
module simplex_element_diameter_unit
    import sed_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COORD_W-1:0]   i_v0_x,
    input  logic [COORD_W-1:0]   i_v0_y,
    input  logic [COORD_W-1:0]   i_v0_z,
    input  logic [COORD_W-1:0]   i_v1_x,
    input  logic [COORD_W-1:0]   i_v1_y,
    input  logic [COORD_W-1:0]   i_v1_z,
    input  logic [COORD_W-1:0]   i_v2_x,
    input  logic [COORD_W-1:0]   i_v2_y,
    input  logic [COORD_W-1:0]   i_v2_z,
    input  logic [COORD_W-1:0]   i_v3_x,
    input  logic [COORD_W-1:0]   i_v3_y,
    input  logic [COORD_W-1:0]   i_v3_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_element_size,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_coord_dims;
    logic [CFG_W-1:0] r_simplex_dims;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_size;
    logic [OUT_W-1:0] n_out_size;

    logic             w_en;
    t_coords          w_coords;
    t_mags            w_mags;
    t_ctl             w_diff_ctl;
    t_sums            w_sums;
    t_ctl             w_sum_ctl;
    logic [SUM_W-1:0] w_best;
    t_ctl             w_max_ctl;
    logic [SUM_W-1:0] w_root;
    t_ctl             w_root_ctl;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    assign w_coords[0] = {i_v0_z, i_v0_y, i_v0_x};
    assign w_coords[1] = {i_v1_z, i_v1_y, i_v1_x};
    assign w_coords[2] = {i_v2_z, i_v2_y, i_v2_x};
    assign w_coords[3] = {i_v3_z, i_v3_y, i_v3_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_dims   <= 2'd3;
            r_simplex_dims <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COORD_DIMS: begin
                    r_coord_dims <= i_cfg_data;
                end
                CFG_SIMPLEX_DIMS: begin
                    r_simplex_dims <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    sed_diff u_diff (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_coords       (w_coords),
        .i_coord_dims   (r_coord_dims),
        .i_simplex_dims (r_simplex_dims),
        .o_mags         (w_mags),
        .o_ctl          (w_diff_ctl)
    );

    sed_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_mags  (w_mags),
        .i_ctl   (w_diff_ctl),
        .o_sums  (w_sums),
        .o_ctl   (w_sum_ctl)
    );

    sed_max u_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_sums  (w_sums),
        .i_ctl   (w_sum_ctl),
        .o_best  (w_best),
        .o_ctl   (w_max_ctl)
    );

    sed_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_value (w_best),
        .i_ctl   (w_max_ctl),
        .o_root  (w_root),
        .o_ctl   (w_root_ctl)
    );

    always_comb begin
        if (w_root_ctl.sat || (w_root > SUM_W'(OUT_MAX))) begin
            n_out_size = OUT_MAX;
        end else begin
            n_out_size = w_root[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_root_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_size <= n_out_size;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_element_size = r_out_size;

endmodule
